/* hdl/two_key_debounce_press_classifier_macros.svh */
// Assertion helpers for the two-key debounce block.
// Each macro expects clk and rst_n in scope.
`ifndef TWO_KEY_DEBOUNCE_PRESS_CLASSIFIER_MACROS_SVH
`define TWO_KEY_DEBOUNCE_PRESS_CLASSIFIER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define TKDPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define TKDPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/tkdpc_pkg.sv */
package tkdpc_pkg;

    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;
    localparam int EV_W   = 2;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 8;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd2000;

    // Configuration register indexes
    localparam logic CFG_DEBOUNCE   = 1'b0;
    localparam logic CFG_LONG_PRESS = 1'b1;

    // Item kinds on the input tuser
    localparam logic ACT_INIT = 1'b0;
    localparam logic ACT_POLL = 1'b1;

    // Event codes
    localparam logic [EV_W-1:0] EV_NONE        = 2'd0;
    localparam logic [EV_W-1:0] EV_POWER_SHORT = 2'd1;
    localparam logic [EV_W-1:0] EV_POWER_LONG  = 2'd2;
    localparam logic [EV_W-1:0] EV_MODE_SHORT  = 2'd3;

    typedef struct packed {
        logic              power_stable;
        logic              power_last_raw;
        logic              power_long_done;
        logic [TIME_W-1:0] power_change_time;
        logic [TIME_W-1:0] power_press_time;
        logic              power_wait_release;
        logic              mode_stable;
        logic              mode_last_raw;
        logic [TIME_W-1:0] mode_change_time;
    } key_state_t;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_time;
        logic [CFG_W-1:0] long_press_time;
    } key_cfg_t;

endpackage

/* hdl/tkdpc_update.sv */
module tkdpc_update
(
    input  tkdpc_pkg::key_state_t          cur,
    input  tkdpc_pkg::key_cfg_t            cfg,
    input  logic                           action,
    input  logic                           power_raw,
    input  logic                           mode_raw,
    input  logic [tkdpc_pkg::TIME_W-1:0]   now_time,
    output tkdpc_pkg::key_state_t          nxt,
    output logic [tkdpc_pkg::EV_W-1:0]     key_event
);

    logic [tkdpc_pkg::TIME_W-1:0] deb_ext;
    logic [tkdpc_pkg::TIME_W-1:0] lpt_ext;
    logic [tkdpc_pkg::TIME_W-1:0] p_elapsed;
    logic [tkdpc_pkg::TIME_W-1:0] m_elapsed;
    logic [tkdpc_pkg::TIME_W-1:0] press_elapsed;
    logic                         p_changed;
    logic                         m_changed;
    logic                         deb_zero;
    logic                         p_settled;
    logic                         m_settled;
    logic                         lpt_zero;
    logic                         press_reached;

    assign deb_ext  = {{(tkdpc_pkg::TIME_W-tkdpc_pkg::CFG_W){1'b0}}, cfg.debounce_time};
    assign lpt_ext  = {{(tkdpc_pkg::TIME_W-tkdpc_pkg::CFG_W){1'b0}}, cfg.long_press_time};
    assign deb_zero = (cfg.debounce_time == '0);
    assign lpt_zero = (cfg.long_press_time == '0);

    // Elapsed times; a raw change this poll restarts the window at zero
    assign p_changed     = (power_raw != cur.power_last_raw);
    assign m_changed     = (mode_raw != cur.mode_last_raw);
    assign p_elapsed     = now_time - cur.power_change_time;
    assign m_elapsed     = now_time - cur.mode_change_time;
    assign press_elapsed = now_time - cur.power_press_time;
    assign p_settled     = p_changed ? deb_zero : (p_elapsed >= deb_ext);
    assign m_settled     = m_changed ? deb_zero : (m_elapsed >= deb_ext);
    assign press_reached = press_elapsed >= lpt_ext;

    always_comb
    begin
        logic [tkdpc_pkg::EV_W-1:0] ev;
        logic                       just_pressed;
        logic                       long_hit;
        nxt          = cur;
        ev           = tkdpc_pkg::EV_NONE;
        just_pressed = 1'b0;
        long_hit     = 1'b0;

        if (action == tkdpc_pkg::ACT_INIT)
        begin
            // Load raw levels at time zero
            nxt.power_stable       = power_raw;
            nxt.power_last_raw     = power_raw;
            nxt.power_long_done    = 1'b0;
            nxt.power_change_time  = '0;
            nxt.power_press_time   = '0;
            nxt.power_wait_release = power_raw;
            nxt.mode_stable        = mode_raw;
            nxt.mode_last_raw      = mode_raw;
            nxt.mode_change_time   = '0;
        end
        else
        begin
            // Track raw power level changes
            if (p_changed)
            begin
                nxt.power_last_raw    = power_raw;
                nxt.power_change_time = now_time;
            end

            if (cur.power_wait_release)
            begin
                // Ignore the key until a settled release, then clear it
                if (!power_raw && p_settled)
                begin
                    nxt.power_stable       = 1'b0;
                    nxt.power_last_raw     = 1'b0;
                    nxt.power_long_done    = 1'b0;
                    nxt.power_change_time  = now_time;
                    nxt.power_press_time   = '0;
                    nxt.power_wait_release = 1'b0;
                end
            end
            else
            begin
                // Accept a settled level change
                if (p_settled && (power_raw != cur.power_stable))
                begin
                    nxt.power_stable = power_raw;
                    if (power_raw)
                    begin
                        nxt.power_press_time = now_time;
                        nxt.power_long_done  = 1'b0;
                        just_pressed         = 1'b1;
                    end
                    else if (!cur.power_long_done)
                    begin
                        ev = tkdpc_pkg::EV_POWER_SHORT;
                    end
                end

                // Long hold check; a fresh press has zero hold time
                long_hit = nxt.power_stable && !nxt.power_long_done &&
                           (just_pressed ? lpt_zero : press_reached);
                if (long_hit)
                begin
                    nxt.power_long_done = 1'b1;
                    ev = tkdpc_pkg::EV_POWER_LONG;
                end
            end

            // Mode key updates only when the power key stayed quiet
            if (ev == tkdpc_pkg::EV_NONE)
            begin
                if (m_changed)
                begin
                    nxt.mode_last_raw    = mode_raw;
                    nxt.mode_change_time = now_time;
                end
                if (m_settled && (mode_raw != cur.mode_stable))
                begin
                    nxt.mode_stable = mode_raw;
                    if (!mode_raw)
                    begin
                        ev = tkdpc_pkg::EV_MODE_SHORT;
                    end
                end
            end
        end
        key_event = ev;
    end

endmodule

/* hdl/two_key_debounce_press_classifier.sv */
// Two-key debouncer and press classifier for a power key and a mode key.
// Input channel s_*: one item per poll or init; tuser selects init (0) or
// poll (1), tdata carries the raw key levels and the millisecond timestamp.
// Output channel m_*: exactly one result item per input item, in order,
// carrying the key event code and the debounced levels of both keys.
// Configuration channel cfg_*: index 0 writes the debounce time, index 1
// the long-press time (both in ms); always ready, write only while idle.
// An accepted item enters the input register, moves to the result register
// once that register is free or being drained, and shows on m_* from then
// on until it is taken.
// Throughput: one item per cycle while the receiver takes results; the key
// state update is a single registered pass of subtract-and-compare logic,
// so back-to-back items each see the state left by the one before.
// Reset clears all key state to released, empties both registers and
// loads the timing registers with 50 ms and 2000 ms.
// When the receiver stalls, the result register holds its item and the
// input register takes one more item; after that s_tready drops until
// the result is taken.
`include "two_key_debounce_press_classifier_macros.svh"

module two_key_debounce_press_classifier
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic                                  cfg_index,
    input  logic [tkdpc_pkg::CFG_W-1:0]           cfg_data,
    // Input items
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [tkdpc_pkg::IN_DATA_W-1:0]       s_tdata,   // power_raw, mode_raw, now_time[31:0], pad
    input  logic                                  s_tuser,   // action
    // Result items
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [tkdpc_pkg::OUT_DATA_W-1:0]      m_tdata    // key_event[1:0], power_held, mode_held, pad
);

    tkdpc_pkg::key_cfg_t            cfg_reg;
    tkdpc_pkg::key_state_t          state_reg;
    tkdpc_pkg::key_state_t          state_next;
    logic [tkdpc_pkg::EV_W-1:0]     event_next;

    logic                           in_valid_reg;
    logic                           in_action_reg;
    logic                           in_power_raw_reg;
    logic                           in_mode_raw_reg;
    logic [tkdpc_pkg::TIME_W-1:0]   in_now_time_reg;

    logic                           out_valid_reg;
    logic [tkdpc_pkg::EV_W-1:0]     out_event_reg;
    logic                           out_power_held_reg;
    logic                           out_mode_held_reg;

    logic                           advance;
    logic                           in_take;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_time   <= tkdpc_pkg::DEBOUNCE_RESET;
            cfg_reg.long_press_time <= tkdpc_pkg::LONG_PRESS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tkdpc_pkg::CFG_DEBOUNCE:   cfg_reg.debounce_time   <= cfg_data;
                tkdpc_pkg::CFG_LONG_PRESS: cfg_reg.long_press_time <= cfg_data;
                default:                   cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Handshake: advance when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_action_reg    <= s_tuser;
            in_power_raw_reg <= s_tdata[0];
            in_mode_raw_reg  <= s_tdata[1];
            in_now_time_reg  <= s_tdata[tkdpc_pkg::TIME_W+1:2];
        end
    end

    tkdpc_update u_update
    (
        .cur       (state_reg),
        .cfg       (cfg_reg),
        .action    (in_action_reg),
        .power_raw (in_power_raw_reg),
        .mode_raw  (in_mode_raw_reg),
        .now_time  (in_now_time_reg),
        .nxt       (state_next),
        .key_event (event_next)
    );

    // Commit key state as the item moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_event_reg      <= event_next;
            out_power_held_reg <= state_next.power_stable;
            out_mode_held_reg  <= state_next.mode_stable;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(tkdpc_pkg::OUT_DATA_W-tkdpc_pkg::EV_W-2){1'b0}},
                       out_mode_held_reg, out_power_held_reg, out_event_reg};

    // Checks on the key logic
    `TKDPC_ASSERT_NOW(a_wait_implies_held, state_reg.power_wait_release,
        state_reg.power_stable, "waiting for release while power key not held")
    `TKDPC_ASSERT_NOW(a_long_held,
        m_tvalid && (out_event_reg == tkdpc_pkg::EV_POWER_LONG),
        out_power_held_reg, "long event with power key released")
    `TKDPC_ASSERT_NOW(a_short_released,
        m_tvalid && (out_event_reg == tkdpc_pkg::EV_POWER_SHORT),
        !out_power_held_reg, "power short event with power key held")
    `TKDPC_ASSERT_NEXT(a_init_no_event,
        advance && (in_action_reg == tkdpc_pkg::ACT_INIT),
        out_event_reg == tkdpc_pkg::EV_NONE, "init item produced an event")

endmodule

/* sim/two_key_debounce_press_classifier_tb.sv */
`timescale 1ns / 1ps

module two_key_debounce_press_classifier_tb;

    localparam int PHASE_ITEMS   = 275;
    localparam int PHASE_COUNT   = 7;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PAD_W         = tkdpc_pkg::IN_DATA_W - tkdpc_pkg::TIME_W - 2;

    // One result item, checked field by field
    typedef struct packed {
        logic [tkdpc_pkg::EV_W-1:0] key_event;
        logic                       power_held;
        logic                       mode_held;
    } key_result_t;

    typedef enum logic {ROW_ITEM, ROW_TIMING} row_kind_t;

    // Directed stimulus row; a timing row carries {debounce, long press} in stamp
    typedef struct packed {
        row_kind_t                    kind;
        logic                         action;
        logic                         power_raw;
        logic                         mode_raw;
        logic [tkdpc_pkg::TIME_W-1:0] stamp;
        logic                         typed;
        key_result_t                  want;
    } dir_row_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic                             cfg_index = tkdpc_pkg::CFG_DEBOUNCE;
    logic [tkdpc_pkg::CFG_W-1:0]      cfg_data = '0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [tkdpc_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                             s_tuser = tkdpc_pkg::ACT_INIT;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [tkdpc_pkg::OUT_DATA_W-1:0] m_tdata;

    // Predicted key state and timing registers
    logic [tkdpc_pkg::CFG_W-1:0]      db_ms;
    logic [tkdpc_pkg::CFG_W-1:0]      lp_ms;
    logic                             pw_stable;
    logic                             pw_last;
    logic                             pw_long_sent;
    logic                             pw_hold_off;
    logic [tkdpc_pkg::TIME_W-1:0]     pw_edge_t;
    logic [tkdpc_pkg::TIME_W-1:0]     pw_press_t;
    logic                             md_stable;
    logic                             md_last;
    logic [tkdpc_pkg::TIME_W-1:0]     md_edge_t;

    key_result_t           due_results[$];
    bit                    steady = 1'b0;
    int                    bad_count = 0;
    int                    cycle_count = 0;
    int                    results_seen = 0;
    int                    items_sent = 0;
    int                    inits_sent = 0;
    int                    settings_used = 0;
    int                    events_seen[4] = '{0, 0, 0, 0};

    two_key_debounce_press_classifier dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // power_raw, mode_raw, now_time[31:0], pad
        .s_tuser   (s_tuser),   // action
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)    // key_event[1:0], power_held, mode_held, pad
    );

    always #5 clk = ~clk;

    // Apply one item to the predicted key state and return its result
    function automatic key_result_t classify_press(input logic act, input logic praw,
                                                  input logic mraw,
                                                  input logic [tkdpc_pkg::TIME_W-1:0] now);
        logic [tkdpc_pkg::EV_W-1:0]   ev;
        logic [tkdpc_pkg::TIME_W-1:0] age;
        ev = tkdpc_pkg::EV_NONE;
        if (act == tkdpc_pkg::ACT_INIT)
        begin
            pw_stable    = praw;
            pw_last      = praw;
            pw_long_sent = 1'b0;
            pw_edge_t    = '0;
            pw_press_t   = '0;
            pw_hold_off  = praw;
            md_stable    = mraw;
            md_last      = mraw;
            md_edge_t    = '0;
        end
        else
        begin
            // Power key: restart the debounce window on every raw edge
            if (praw != pw_last)
            begin
                pw_last   = praw;
                pw_edge_t = now;
            end
            age = now - pw_edge_t;
            if (pw_hold_off)
            begin
                // Pressed at init: only a settled release clears it, silently
                if (!praw && age >= db_ms)
                begin
                    pw_stable    = 1'b0;
                    pw_last      = 1'b0;
                    pw_long_sent = 1'b0;
                    pw_edge_t    = now;
                    pw_press_t   = '0;
                    pw_hold_off  = 1'b0;
                end
            end
            else
            begin
                if (age >= db_ms && praw != pw_stable)
                begin
                    pw_stable = praw;
                    if (praw)
                    begin
                        pw_press_t   = now;
                        pw_long_sent = 1'b0;
                    end
                    else if (!pw_long_sent)
                        ev = tkdpc_pkg::EV_POWER_SHORT;
                end
                age = now - pw_press_t;
                if (pw_stable && !pw_long_sent && age >= lp_ms)
                begin
                    pw_long_sent = 1'b1;
                    ev           = tkdpc_pkg::EV_POWER_LONG;
                end
            end
            // Mode key only moves on a poll without a power event
            if (ev == tkdpc_pkg::EV_NONE)
            begin
                if (mraw != md_last)
                begin
                    md_last   = mraw;
                    md_edge_t = now;
                end
                age = now - md_edge_t;
                if (age >= db_ms && mraw != md_stable)
                begin
                    md_stable = mraw;
                    if (!mraw)
                        ev = tkdpc_pkg::EV_MODE_SHORT;
                end
            end
        end
        return {ev, pw_stable, md_stable};
    endfunction

    function automatic dir_row_t mk_row(input row_kind_t kind, input logic act,
                                        input logic praw, input logic mraw,
                                        input logic [tkdpc_pkg::TIME_W-1:0] stamp,
                                        input logic typed,
                                        input logic [tkdpc_pkg::EV_W-1:0] ev,
                                        input logic ph, input logic mh);
        dir_row_t r;
        r.kind      = kind;
        r.action    = act;
        r.power_raw = praw;
        r.mode_raw  = mraw;
        r.stamp     = stamp;
        r.typed     = typed;
        r.want      = {ev, ph, mh};
        return r;
    endfunction

    // Offer one item, after a random gap outside the steady stretch, then record its expected result
    task automatic send_item(input logic act, input logic praw, input logic mraw,
                             input logic [tkdpc_pkg::TIME_W-1:0] now, input logic typed,
                             input key_result_t want);
        key_result_t predicted;
        while (!steady && $urandom_range(0, 99) < 33)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{PAD_W{1'b0}}, now, mraw, praw};
        do @(posedge clk); while (!s_tready);
        predicted = classify_press(act, praw, mraw, now);
        due_results.push_back(typed ? want : predicted);
        items_sent++;
        if (act == tkdpc_pkg::ACT_INIT)
            inits_sent++;
    endtask

    // Stop offering items and wait until every result has drained
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both timing registers while the block is idle
    task automatic set_timing(input logic [tkdpc_pkg::CFG_W-1:0] db,
                              input logic [tkdpc_pkg::CFG_W-1:0] lp);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= tkdpc_pkg::CFG_DEBOUNCE;
        cfg_data  <= db;
        do @(posedge clk); while (!cfg_ready);
        db_ms = db;
        cfg_index <= tkdpc_pkg::CFG_LONG_PRESS;
        cfg_data  <= lp;
        do @(posedge clk); while (!cfg_ready);
        lp_ms = lp;
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Receiver stalls at random outside the steady stretch
    always @(posedge clk)
        m_tready <= steady || ($urandom_range(0, 99) >= 33);

    // Compare each result item with the oldest expectation
    always @(posedge clk)
    begin : check_results
        key_result_t got;
        key_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.key_event  = m_tdata[1:0];
            got.power_held = m_tdata[2];
            got.mode_held  = m_tdata[3];
            results_seen++;
            events_seen[got.key_event]++;
            if (due_results.size() == 0)
            begin
                $error("result item with nothing expected: m_tdata=%h", m_tdata);
                bad_count++;
            end
            else
            begin
                want = due_results.pop_front();
                if (got.key_event !== want.key_event)
                begin
                    $error("key_event: expected %0d, got %0d", want.key_event, got.key_event);
                    bad_count++;
                end
                if (got.power_held !== want.power_held)
                begin
                    $error("power_held: expected %0d, got %0d",
                           want.power_held, got.power_held);
                    bad_count++;
                end
                if (got.mode_held !== want.mode_held)
                begin
                    $error("mode_held: expected %0d, got %0d", want.mode_held, got.mode_held);
                    bad_count++;
                end
            end
        end
    end

    // Guard against a hang
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin : stimulus
        dir_row_t                     rows[$];
        dir_row_t                     r;
        logic [tkdpc_pkg::TIME_W-1:0] clock_ms;
        logic [tkdpc_pkg::CFG_W-1:0]  db;
        logic [tkdpc_pkg::CFG_W-1:0]  lp;
        logic                         p_tgt;
        logic                         m_tgt;
        logic                         praw;
        logic                         mraw;
        int unsigned                  dbv;
        int unsigned                  lpv;
        int unsigned                  step;
        int unsigned                  pick;

        // Reset values of the predicted state
        db_ms        = tkdpc_pkg::DEBOUNCE_RESET;
        lp_ms        = tkdpc_pkg::LONG_PRESS_RESET;
        pw_stable    = 1'b0;
        pw_last      = 1'b0;
        pw_long_sent = 1'b0;
        pw_hold_off  = 1'b0;
        pw_edge_t    = '0;
        pw_press_t   = '0;
        md_stable    = 1'b0;
        md_last      = 1'b0;
        md_edge_t    = '0;

        // Directed table, first at the reset timing of 50 ms and 2000 ms
        rows.push_back(mk_row(ROW_ITEM, tkdpc_pkg::ACT_POLL, 1'b0, 1'b0, 32'd0, 1'b1,
                              tkdpc_pkg::EV_NONE, 1'b0, 1'b0));
        // Power pressed at init: held off until a settled release
        rows.push_back(mk_row(ROW_ITEM, tkdpc_pkg::ACT_INIT, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1,
                              tkdpc_pkg::EV_NONE, 1'b1, 1'b1));
        rows.push_back(mk_row(ROW_ITEM, tkdpc_pkg::ACT_POLL, 1'b1, 1'b1, 32'd10, 1'b0,
                              tkdpc_pkg::EV_NONE, 1'b0, 1'b0));
        rows.push_back(mk_row(ROW_ITEM, tkdpc_pkg::ACT_POLL, 1'b0, 1'b1, 32'd20, 1'b0,
                              tkdpc_pkg::EV_NONE, 1'b0, 1'b0));
        rows.push_back(mk_row(ROW_ITEM, tkdpc_pkg::ACT_POLL, 1'b0, 1'b0, 32'd100, 1'b0,
                              tkdpc_pkg::EV_NONE, 1'b0, 1'b0));
        rows.push_back(mk_row(ROW_ITEM, tkdpc_pkg::ACT_POLL, 1'b0, 1'b0, 32'd150, 1'b0,
                              tkdpc_pkg::EV_NONE, 1'b0, 1'b0));
        // Press, bounce, long hold, release after the long event
        rows.push_back(mk_row(ROW_ITEM, tkdpc_pkg::ACT_POLL, 1'b1, 1'b0, 32'd200, 1'b0,
                              tkdpc_pkg::EV_NONE, 1'b0, 1'b0));
        rows.push_back(mk_row(ROW_ITEM, tkdpc_pkg::ACT_POLL, 1'b1, 1'b0, 32'd250, 1'b0,
                              tkdpc_pkg::EV_NONE, 1'b0, 1'b0));
        rows.push_back(mk_row(ROW_ITEM, tkdpc_pkg::ACT_POLL, 1'b0, 1'b0, 32'd300, 1'b0,
                              tkdpc_pkg::EV_NONE, 1'b0, 1'b0));
        rows.push_back(mk_row(ROW_ITEM, tkdpc_pkg::ACT_POLL, 1'b1, 1'b0, 32'd320, 1'b0,
                              tkdpc_pkg::EV_NONE, 1'b0, 1'b0));
        rows.push_back(mk_row(ROW_ITEM, tkdpc_pkg::ACT_POLL, 1'b1, 1'b0, 32'd2250, 1'b0,
                              tkdpc_pkg::EV_NONE, 1'b0, 1'b0));
        rows.push_back(mk_row(ROW_ITEM, tkdpc_pkg::ACT_POLL, 1'b0, 1'b0, 32'd2300, 1'b0,
                              tkdpc_pkg::EV_NONE, 1'b0, 1'b0));
        rows.push_back(mk_row(ROW_ITEM, tkdpc_pkg::ACT_POLL, 1'b0, 1'b0, 32'd2350, 1'b0,
                              tkdpc_pkg::EV_NONE, 1'b0, 1'b0));
        rows.push_back(mk_row(ROW_ITEM, tkdpc_pkg::ACT_INIT, 1'b0, 1'b0, 32'h1234_5678, 1'b1,
                              tkdpc_pkg::EV_NONE, 1'b0, 1'b0));
        // Timestamp wrap, then power short with a mode change held back
        rows.push_back(mk_row(ROW_ITEM, tkdpc_pkg::ACT_POLL, 1'b1, 1'b1, 32'hFFFF_FFF0, 1'b0,
                              tkdpc_pkg::EV_NONE, 1'b0, 1'b0));
        rows.push_back(mk_row(ROW_ITEM, tkdpc_pkg::ACT_POLL, 1'b1, 1'b1, 32'h0000_0030, 1'b0,
                              tkdpc_pkg::EV_NONE, 1'b0, 1'b0));
        rows.push_back(mk_row(ROW_ITEM, tkdpc_pkg::ACT_POLL, 1'b0, 1'b0, 32'h0000_0040, 1'b0,
                              tkdpc_pkg::EV_NONE, 1'b0, 1'b0));
        rows.push_back(mk_row(ROW_ITEM, tkdpc_pkg::ACT_POLL, 1'b0, 1'b0, 32'h0000_0080, 1'b0,
                              tkdpc_pkg::EV_NONE, 1'b0, 1'b0));
        rows.push_back(mk_row(ROW_ITEM, tkdpc_pkg::ACT_POLL, 1'b0, 1'b0, 32'h0000_0081, 1'b0,
                              tkdpc_pkg::EV_NONE, 1'b0, 1'b0));
        // Zero times: accept and go long on the same poll
        rows.push_back(mk_row(ROW_TIMING, tkdpc_pkg::ACT_POLL, 1'b0, 1'b0, 32'h0000_0000, 1'b0,
                              tkdpc_pkg::EV_NONE, 1'b0, 1'b0));
        rows.push_back(mk_row(ROW_ITEM, tkdpc_pkg::ACT_POLL, 1'b1, 1'b1, 32'd5, 1'b1,
                              tkdpc_pkg::EV_POWER_LONG, 1'b1, 1'b0));
        rows.push_back(mk_row(ROW_ITEM, tkdpc_pkg::ACT_POLL, 1'b0, 1'b1, 32'd6, 1'b0,
                              tkdpc_pkg::EV_NONE, 1'b0, 1'b0));
        rows.push_back(mk_row(ROW_ITEM, tkdpc_pkg::ACT_POLL, 1'b0, 1'b0, 32'd7, 1'b0,
                              tkdpc_pkg::EV_NONE, 1'b0, 1'b0));
        // Largest times
        rows.push_back(mk_row(ROW_TIMING, tkdpc_pkg::ACT_POLL, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0,
                              tkdpc_pkg::EV_NONE, 1'b0, 1'b0));
        rows.push_back(mk_row(ROW_ITEM, tkdpc_pkg::ACT_POLL, 1'b1, 1'b0, 32'd10, 1'b0,
                              tkdpc_pkg::EV_NONE, 1'b0, 1'b0));
        rows.push_back(mk_row(ROW_ITEM, tkdpc_pkg::ACT_POLL, 1'b1, 1'b0, 32'd65545, 1'b0,
                              tkdpc_pkg::EV_NONE, 1'b0, 1'b0));
        rows.push_back(mk_row(ROW_ITEM, tkdpc_pkg::ACT_POLL, 1'b1, 1'b0, 32'd131080, 1'b0,
                              tkdpc_pkg::EV_NONE, 1'b0, 1'b0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (rows[i])
        begin
            r = rows[i];
            if (r.kind == ROW_TIMING)
                set_timing(r.stamp[31:16], r.stamp[15:0]);
            else
                send_item(r.action, r.power_raw, r.mode_raw, r.stamp, r.typed, r.want);
        end

        // Random phases: key gestures with bounce under several timings
        p_tgt = 1'b0;
        m_tgt = 1'b0;
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            case (ph)
                0:       db = 16'd3;
                1:       db = 16'd0;
                2:       db = 16'hFFFF;
                3:       db = 16'd10;
                4:       db = 16'($urandom_range(0, 30));
                5:       db = 16'd1;
                default: db = 16'hFFFF;
            endcase
            case (ph)
                0:       lp = 16'd40;
                1:       lp = 16'd0;
                2:       lp = 16'hFFFF;
                3:       lp = 16'd200;
                4:       lp = 16'($urandom_range(0, 300));
                5:       lp = 16'hFFFF;
                default: lp = 16'd0;
            endcase
            set_timing(db, lp);
            steady   = (ph == 3);
            clock_ms = $urandom;
            dbv      = db_ms;
            lpv      = lp_ms;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    step = $urandom_range(0, dbv / 3 + 1);
                else if (pick < 85)
                    step = $urandom_range(dbv / 2, dbv + dbv / 2 + 1);
                else if (pick < 97)
                    step = $urandom_range(0, lpv + dbv + 2);
                else
                    step = $urandom;
                clock_ms = clock_ms + step;

                // Occasionally change what each key is doing, with bounce on top
                if ($urandom_range(0, 99) < 8)
                    p_tgt = ~p_tgt;
                if ($urandom_range(0, 99) < 8)
                    m_tgt = ~m_tgt;
                praw = ($urandom_range(0, 99) < 15) ? ~p_tgt : p_tgt;
                mraw = ($urandom_range(0, 99) < 15) ? ~m_tgt : m_tgt;

                if ($urandom_range(0, 99) < 3)
                    send_item(tkdpc_pkg::ACT_INIT, praw, mraw, $urandom, 1'b0, '0);
                else
                    send_item(tkdpc_pkg::ACT_POLL, praw, mraw, clock_ms, 1'b0, '0);
            end
        end
        steady = 1'b0;

        drain_results();
        $display("Checked %0d results from %0d items (%0d inits) over %0d timing settings",
                 results_seen, items_sent, inits_sent, settings_used);
        $display("Events seen: power short %0d, power long %0d, mode short %0d",
                 events_seen[tkdpc_pkg::EV_POWER_SHORT], events_seen[tkdpc_pkg::EV_POWER_LONG],
                 events_seen[tkdpc_pkg::EV_MODE_SHORT]);
        if (bad_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
